[hw/rtl/oli_pkg.sv]
// ----------------------------------------------------------------------------
// oli_pkg: shared types and codes for the ordered list
// Holds the opcode and status codes of the list transactions, the control
// state of the top level and the command kinds given to the cell chain.
// ----------------------------------------------------------------------------
package oli_pkg;

   // entry payload width
   localparam int ValueWidth = 32;

   // opcodes carried on req_tuser
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // status codes carried on rsp_tuser
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_NOPOS = 2'd3;

   // top level control state
   typedef enum logic {
      FSM_IDLE,
      FSM_READ
   } fsm_state_type;

   // what every cell of the chain is told to do
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_DELETE,
      CMD_ROTATE
   } cmd_kind_type;

endpackage

[hw/rtl/oli_cell.sv]
// ----------------------------------------------------------------------------
// oli_cell: one storage cell of the list chain
// Holds one entry and, on command, takes the new value, the entry of its
// left or right neighbor, or the head entry to close a rotation.
// ----------------------------------------------------------------------------
module oli_cell #(
   parameter int IDX = 0,
   parameter int CW  = 7
) (
   input  logic                           clock,
   input  oli_pkg::cmd_kind_type          cmd,
   input  logic [CW-1:0]                  slot,
   input  logic [CW-1:0]                  count,
   input  logic [oli_pkg::ValueWidth-1:0] ins_value,
   input  logic [oli_pkg::ValueWidth-1:0] prev_value,
   input  logic [oli_pkg::ValueWidth-1:0] next_value,
   input  logic [oli_pkg::ValueWidth-1:0] first_value,
   output logic [oli_pkg::ValueWidth-1:0] value
);

   localparam logic [CW-1:0] IdxC  = CW'(IDX);
   localparam logic [CW-1:0] IdxP1 = CW'(IDX + 1);

   logic [oli_pkg::ValueWidth-1:0] value_ff;
   logic [oli_pkg::ValueWidth-1:0] value_in;

   // next entry of this cell
   always_comb begin
      value_in = value_ff;
      case (cmd)
         oli_pkg::CMD_INSERT: begin
            if (IdxC == slot) begin
               value_in = ins_value;
            end else if ((IdxC > slot) && (IdxC <= count)) begin
               value_in = prev_value;
            end
         end
         oli_pkg::CMD_DELETE: begin
            if ((IdxC >= slot) && (IdxP1 < count)) begin
               value_in = next_value;
            end
         end
         oli_pkg::CMD_ROTATE: begin
            if (IdxP1 < count) begin
               value_in = next_value;
            end else if (IdxP1 == count) begin
               value_in = first_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // entry storage, payload only
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[hw/rtl/ordered_list_insert_delete.sv]
// Ordered list of up to DEPTH signed 32-bit ids held in a chain of cells.
// Insert, delete and any unused opcode each give one result; the next
// transaction is taken as soon as the output register is empty or being
// drained. A read of a non-empty list gives count results, one entry per
// cycle while the receiver takes them, because the chain rotates one cell
// toward the head for each result and the head cell drives the output; after
// the read the list is back in its original order. A read of an empty list
// gives one result. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// ordered_list_insert_delete: positional insert and delete list
// Top level: decodes list transactions, drives the cell chain and holds
// the result register.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], position[38:32], zero[39]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // entry_value[31:0], entry_count[38:32], zero[39]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int WW = (CW > 7) ? CW : 7;
   localparam int VW = oli_pkg::ValueWidth;
   localparam logic [CW-1:0] DepthC = CW'(DEPTH);

   // control state
   oli_pkg::fsm_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;
   logic          rsp_last_ff, rsp_last_in;

   // chain control
   oli_pkg::cmd_kind_type cmd;
   logic [CW-1:0] slot;
   logic [VW-1:0] cell_value [DEPTH];

   // transaction decode
   logic [1:0]    req_op;
   logic [VW-1:0] req_value;
   logic [WW-1:0] pos_w;
   logic [WW-1:0] count_w;
   logic [WW-1:0] rsp_count_w;
   logic          slot_free;
   logic          req_fire;
   logic          read_last;

   assign req_op    = req_tuser;
   assign req_value = req_tdata[31:0];
   assign pos_w     = WW'(req_tdata[38:32]);
   assign count_w   = WW'(count_ff);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == oli_pkg::FSM_IDLE) && slot_free;
   assign req_fire  = req_tvalid && req_tready;
   assign read_last = (rd_idx_ff == (count_ff - CW'(1)));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         oli_pkg::FSM_IDLE: begin
            if (req_fire && (req_op == oli_pkg::OP_READ) && (count_ff != '0)) begin
               state_in = oli_pkg::FSM_READ;
            end
         end
         oli_pkg::FSM_READ: begin
            if (slot_free && read_last) begin
               state_in = oli_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = oli_pkg::FSM_IDLE;
         end
      endcase
   end

   // chain commands, count and result register
   always_comb begin
      cmd           = oli_pkg::CMD_HOLD;
      slot          = '0;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         oli_pkg::FSM_IDLE: begin
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = oli_pkg::STAT_OK;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               rd_idx_in     = '0;
               case (req_op)
                  oli_pkg::OP_INSERT: begin
                     if (count_ff == DepthC) begin
                        rsp_status_in = oli_pkg::STAT_FULL;
                     end else begin
                        cmd = oli_pkg::CMD_INSERT;
                        if (pos_w == '0) begin
                           slot = '0;
                        end else if ((pos_w - WW'(1)) > count_w) begin
                           slot = count_ff;
                        end else begin
                           slot = CW'(pos_w - WW'(1));
                        end
                        count_in = count_ff + CW'(1);
                     end
                  end
                  oli_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = oli_pkg::STAT_EMPTY;
                     end else if ((pos_w == '0) || (pos_w > count_w)) begin
                        rsp_status_in = oli_pkg::STAT_NOPOS;
                     end else begin
                        cmd      = oli_pkg::CMD_DELETE;
                        slot     = CW'(pos_w - WW'(1));
                        count_in = count_ff - CW'(1);
                     end
                  end
                  oli_pkg::OP_READ: begin
                     // a non-empty read gives no result here; the read state streams the entries
                     if (count_ff == '0) begin
                        rsp_status_in = oli_pkg::STAT_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                     end
                  end
                  default: begin
                     rsp_status_in = oli_pkg::STAT_OK;
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         oli_pkg::FSM_READ: begin
            if (slot_free) begin
               cmd           = oli_pkg::CMD_ROTATE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = oli_pkg::STAT_OK;
               rsp_value_in  = cell_value[0];
               rsp_count_in  = count_ff;
               rsp_last_in   = read_last;
               rd_idx_in     = read_last ? '0 : (rd_idx_ff + CW'(1));
            end
         end
         default: begin
            cmd = oli_pkg::CMD_HOLD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oli_pkg::FSM_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // chain of cells, head at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VW-1:0] prev_value;
      logic [VW-1:0] next_value;

      if (i == 0) begin : g_head
         assign prev_value = '0;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_value = '0;
      end else begin : g_link
         assign next_value = cell_value[i+1];
      end

      oli_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .slot        (slot),
         .count       (count_ff),
         .ins_value   (req_value),
         .prev_value  (prev_value),
         .next_value  (next_value),
         .first_value (cell_value[0]),
         .value       (cell_value[i])
      );
   end

   // result port
   assign rsp_count_w = WW'(rsp_count_ff);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = {1'b0, rsp_count_w[6:0], rsp_value_ff};
   assign rsp_tuser   = rsp_status_ff;
   assign rsp_tlast   = rsp_last_ff;

`ifndef SYNTHESIS
   // list never holds more than DEPTH entries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthC)
      else $error("entry count above depth");

   // read index stays inside the held entries
   a_read_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == oli_pkg::FSM_READ) |-> (rd_idx_ff < count_ff))
      else $error("read index past list end");

   // an accepted insert on a non-full list grows it by one
   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == oli_pkg::OP_INSERT) && (count_ff != DepthC))
      |=> (count_ff == ($past(count_ff) + CW'(1))))
      else $error("insert did not grow list");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ordered list
// A directed table covers the empty, full-range, boundary-position and
// unused-opcode cases. Random phases then fill the list to full, mix
// operations and drain it back to empty. Every accepted request is run
// through a shadow list kept here; every response transaction is compared
// field by field with the oldest predicted one. Both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module tb;
   import oli_pkg::*;

   localparam int DEPTH        = 64;
   localparam int RANDOM_ITEMS = 446;   // random requests after the directed table
   localparam int QUIET_LIMIT  = 1000;  // cycles with no transaction on either side
   localparam int DRAIN_CYCLES = 80;    // wait for stray responses after the last expected one

   // opcode value that leaves the list unchanged
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // bias of the random generator
   typedef enum logic [1:0] {
      LEAN_GROW,
      LEAN_SHRINK,
      LEAN_MIXED
   } lean_type;

   // one response transaction
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] entry_value;
      logic [6:0]         entry_count;
      logic               last;
   } list_rsp_type;

   // one row of the directed table; status and count are used when fixed is set
   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] id;
      logic [6:0]         pos;
      logic               fixed;
      logic [1:0]         status;
      logic [6:0]         count;
   } list_cmd_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // value[31:0], position[38:32], zero[39]
   logic [1:0]  req_tuser  = '0;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // entry_value[31:0], entry_count[38:32], zero[39]
   logic [1:0]  rsp_tuser;         // status[1:0]
   logic        rsp_tlast;

   logic signed [31:0] list_ids[$];        // shadow copy of the held ids
   list_rsp_type       list_responses[$];  // responses still to arrive
   list_cmd_type       directed_cmds[$];
   int                 error_count  = 0;
   int                 quiet_cycles = 0;
   int                 burst_left   = 0;
   int                 random_sent  = 0;
   logic [7:0]         drain_tick   = '0;

   ordered_list_insert_delete #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always #2 clock = ~clock;

   // queue one response, count taken after the operation
   function automatic void note_result(input logic [1:0] status,
                                       input logic signed [31:0] id, input logic last);
      list_responses.push_back('{status, id, 7'(list_ids.size()), last});
   endfunction

   // apply one list transaction to the shadow list
   function automatic void predict_list_op(input logic [1:0] op,
                                           input logic signed [31:0] id,
                                           input logic [6:0] pos);
      int held;
      int slot;
      held = list_ids.size();
      case (op)
         OP_INSERT: begin
            if (held >= DEPTH) begin
               note_result(STAT_FULL, 32'sd0, 1'b1);
            end else begin
               slot = (pos == 7'd0) ? 0 : int'(pos) - 1;
               if (slot > held) slot = held;
               list_ids.insert(slot, id);
               note_result(STAT_OK, 32'sd0, 1'b1);
            end
         end
         OP_DELETE: begin
            if (held == 0) begin
               note_result(STAT_EMPTY, 32'sd0, 1'b1);
            end else if (pos == 7'd0 || int'(pos) > held) begin
               note_result(STAT_NOPOS, 32'sd0, 1'b1);
            end else begin
               list_ids.delete(int'(pos) - 1);
               note_result(STAT_OK, 32'sd0, 1'b1);
            end
         end
         OP_READ: begin
            if (held == 0) begin
               note_result(STAT_EMPTY, 32'sd0, 1'b1);
            end else begin
               for (int i = 0; i < held; i++)
                  note_result(STAT_OK, list_ids[i], i == held - 1);
            end
         end
         default: begin
            note_result(STAT_OK, 32'sd0, 1'b1);
         end
      endcase
   endfunction

   // present one request, wait for its transaction, then maybe pause
   // a fixed row replaces the predicted response with the typed-in one
   task automatic send_list_op(input logic [1:0] op, input logic signed [31:0] id,
                               input logic [6:0] pos, input logic fixed,
                               input logic [1:0] status, input logic [6:0] count);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, pos, id};
      do @(posedge clock); while (!req_tready);
      predict_list_op(op, id, pos);
      if (fixed)
         list_responses[list_responses.size() - 1] = '{status, 32'sd0, count, 1'b1};
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // one random request, leaning toward growth, shrinkage or neither
   task automatic random_list_op(input lean_type lean);
      int         roll;
      int         held;
      logic [1:0] op;
      logic [6:0] pos;
      held = list_ids.size();
      roll = $urandom_range(0, 99);
      if (roll < 4)
         op = OP_UNUSED;
      else if (roll < 12)
         op = OP_READ;
      else if (lean == LEAN_GROW)
         op = (roll < 88) ? OP_INSERT : OP_DELETE;
      else if (lean == LEAN_SHRINK)
         op = (roll < 88) ? OP_DELETE : OP_INSERT;
      else
         op = roll[0] ? OP_INSERT : OP_DELETE;
      // mostly valid positions, sometimes anything
      if ($urandom_range(0, 9) == 0)
         pos = 7'($urandom_range(0, 127));
      else if (op == OP_DELETE)
         pos = (held == 0) ? 7'd1 : 7'($urandom_range(1, held));
      else
         pos = 7'($urandom_range(1, held + 1));
      send_list_op(op, $urandom, pos, 1'b0, STAT_OK, 7'd0);
      random_sent++;
   endtask

   // receiver stall pattern, changes character with the top two bits of drain_tick
   always @(posedge clock) begin
      drain_tick <= drain_tick + 8'd1;
      case (drain_tick[7:6])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_tready <= ((drain_tick % 5) >= 2);
         default: rsp_tready <= (drain_tick[3:0] < 4'd12);
      endcase
   end

   // response checking
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (list_responses.size() == 0) begin
            $error("unexpected response transaction: tdata %h tuser %0d tlast %0d",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = list_responses.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[31:0] !== want.entry_value) begin
               $error("entry_value: expected %0d, got %0d",
                      want.entry_value, $signed(rsp_tdata[31:0]));
               error_count++;
            end
            if (rsp_tdata[38:32] !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      want.entry_count, rsp_tdata[38:32]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int phase;

      // empty list behavior
      directed_cmds.push_back('{OP_READ,   32'sd0,          7'd1,   1'b1, STAT_EMPTY, 7'd0});
      directed_cmds.push_back('{OP_DELETE, 32'sd0,          7'd1,   1'b1, STAT_EMPTY, 7'd0});
      // extremes of value, position zero goes to the front, past end appends
      directed_cmds.push_back('{OP_INSERT, 32'sh8000_0000,  7'd0,   1'b1, STAT_OK,    7'd1});
      directed_cmds.push_back('{OP_INSERT, 32'sh7fff_ffff,  7'd127, 1'b1, STAT_OK,    7'd2});
      directed_cmds.push_back('{OP_INSERT, 32'sd0,          7'd1,   1'b1, STAT_OK,    7'd3});
      directed_cmds.push_back('{OP_INSERT, -32'sd1,         7'd2,   1'b1, STAT_OK,    7'd4});
      directed_cmds.push_back('{OP_READ,   32'sd0,          7'd0,   1'b0, STAT_OK,    7'd0});
      // bad delete positions
      directed_cmds.push_back('{OP_DELETE, 32'sd0,          7'd0,   1'b1, STAT_NOPOS, 7'd4});
      directed_cmds.push_back('{OP_DELETE, 32'sd0,          7'd127, 1'b1, STAT_NOPOS, 7'd4});
      directed_cmds.push_back('{OP_DELETE, 32'sd0,          7'd5,   1'b1, STAT_NOPOS, 7'd4});
      directed_cmds.push_back('{OP_UNUSED, 32'sh1234_5678,  7'd3,   1'b1, STAT_OK,    7'd4});
      // delete at the tail and the head
      directed_cmds.push_back('{OP_DELETE, 32'sd0,          7'd4,   1'b1, STAT_OK,    7'd3});
      directed_cmds.push_back('{OP_DELETE, 32'sd0,          7'd1,   1'b1, STAT_OK,    7'd2});
      directed_cmds.push_back('{OP_READ,   32'sd0,          7'd0,   1'b0, STAT_OK,    7'd0});
      // insert exactly one past the end, then in the middle
      directed_cmds.push_back('{OP_INSERT, 32'sh5555_5555,  7'd3,   1'b1, STAT_OK,    7'd3});
      directed_cmds.push_back('{OP_INSERT, 32'shaaaa_aaaa,  7'd2,   1'b1, STAT_OK,    7'd4});
      directed_cmds.push_back('{OP_READ,   32'sd0,          7'd0,   1'b0, STAT_OK,    7'd0});
      // drain to empty
      directed_cmds.push_back('{OP_DELETE, 32'sd0,          7'd2,   1'b1, STAT_OK,    7'd3});
      directed_cmds.push_back('{OP_DELETE, 32'sd0,          7'd1,   1'b1, STAT_OK,    7'd2});
      directed_cmds.push_back('{OP_DELETE, 32'sd0,          7'd1,   1'b1, STAT_OK,    7'd1});
      directed_cmds.push_back('{OP_DELETE, 32'sd0,          7'd1,   1'b1, STAT_OK,    7'd0});
      directed_cmds.push_back('{OP_READ,   32'sd0,          7'd0,   1'b1, STAT_EMPTY, 7'd0});
      directed_cmds.push_back('{OP_UNUSED, -32'sd1,         7'd127, 1'b1, STAT_OK,    7'd0});
      // empty wins over a bad position
      directed_cmds.push_back('{OP_DELETE, 32'sd0,          7'd0,   1'b1, STAT_EMPTY, 7'd0});

      burst_left = $urandom_range(1, 20);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_cmds[i]) begin
         send_list_op(directed_cmds[i].op, directed_cmds[i].id, directed_cmds[i].pos,
                      directed_cmds[i].fixed, directed_cmds[i].status,
                      directed_cmds[i].count);
      end

      // random phases: fill past full, mix, drain past empty, mix
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (phase % 4)
            0: begin
               do random_list_op(LEAN_GROW);
               while ((list_ids.size() < DEPTH) && (random_sent < RANDOM_ITEMS));
               repeat ($urandom_range(1, 3)) random_list_op(LEAN_GROW);
            end
            2: begin
               do random_list_op(LEAN_SHRINK);
               while ((list_ids.size() > 0) && (random_sent < RANDOM_ITEMS));
               repeat ($urandom_range(1, 3)) random_list_op(LEAN_SHRINK);
            end
            default: begin
               for (int k = 0; (k < 30) && (random_sent < RANDOM_ITEMS); k++)
                  random_list_op(LEAN_MIXED);
            end
         endcase
         phase++;
      end
      req_tvalid <= 1'b0;

      // wait for every response, then watch for strays
      while (list_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/oli_pkg.sv
hw/rtl/oli_cell.sv
hw/rtl/ordered_list_insert_delete.sv
tb/tb.sv
